FILE: src/tsf_pkg.sv
// Shared types, constants and helpers for the token semaphore block.
`default_nettype none
package tsf_pkg;

  localparam int NUM_REQ  = 64;
  localparam int ID_W     = 6;
  localparam int TIME_W   = 32;
  localparam int MAX_HOLD = 8;
  localparam int QLEN_W   = 7;
  localparam int CNT_W    = 4;
  localparam int CFG_W    = 32;

  localparam logic [2:0] MODE_REQUEST   = 3'd0;
  localparam logic [2:0] MODE_RELEASE   = 3'd1;
  localparam logic [2:0] MODE_CANCEL    = 3'd2;
  localparam logic [2:0] MODE_GONE      = 3'd3;
  localparam logic [2:0] MODE_RESET_ALL = 3'd4;

  localparam logic [1:0] KIND_REPLY    = 2'd0;
  localparam logic [1:0] KIND_GRANT    = 2'd1;
  localparam logic [1:0] KIND_RELEASED = 2'd2;
  localparam logic [1:0] KIND_ACK      = 2'd3;

  localparam logic [2:0] ST_GRANTED = 3'd0;
  localparam logic [2:0] ST_HELD    = 3'd1;
  localparam logic [2:0] ST_QUEUED  = 3'd2;
  localparam logic [2:0] ST_COOL    = 3'd3;
  localparam logic [2:0] ST_ENQUEUE = 3'd4;

  localparam logic CFG_MAX_HOLDERS = 1'b0;
  localparam logic CFG_COOLDOWN    = 1'b1;

  typedef struct packed {
    logic [2:0]        mode;
    logic [ID_W-1:0]   requester_id;
    logic [TIME_W-1:0] now_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   who;
    logic [2:0]        status;
    logic              holds_token;
    logic [QLEN_W-1:0] queue_length;
    logic [CNT_W-1:0]  active_count;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic            re;
    logic [ID_W-1:0] raddr;
    logic            we;
    logic [ID_W-1:0] waddr;
    logic [ID_W-1:0] wdata;
  } qmem_req_t;

  typedef struct packed {
    logic              re;
    logic [ID_W-1:0]   raddr;
    logic              we;
    logic [ID_W-1:0]   waddr;
    logic [TIME_W-1:0] wdata;
  } smem_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_REQ_SCAN, S_REQ_DECIDE, S_RM,
    S_GP_POP, S_GP_RD, S_GP_CHK, S_RST_SCAN, S_RST_ACK, S_FINISH
  } state_t;

  function automatic out_item_t make_out(logic [1:0] kind, logic [ID_W-1:0] who,
                                         logic [2:0] status, logic holds,
                                         logic [QLEN_W-1:0] qlen,
                                         logic [CNT_W-1:0] cnt);
    out_item_t o;
    o.kind         = kind;
    o.who          = who;
    o.status       = status;
    o.holds_token  = holds;
    o.queue_length = qlen;
    o.active_count = cnt;
    o.last         = 1'b0;
    return o;
  endfunction

  function automatic logic cooling(logic [TIME_W-1:0] now, logic [TIME_W-1:0] stamp,
                                   logic [TIME_W-1:0] cd, logic stamp_ok);
    logic [TIME_W-1:0] diff;
    diff = now - stamp;
    return (cd != '0) && stamp_ok && (diff < cd);
  endfunction

endpackage
`default_nettype wire

FILE: src/token_semaphore_fifo_cooldown_top.sv
// Token semaphore with FIFO wait queue and re-grant cooldown: control and state.
// One item is taken while busy is low; results then appear one per strobe on valid,
// the final one marked by last, and the receiver cannot stall them. A request, cancel
// or gone walks the queue through the queue memory read port, a grant pass examines
// each entry with a queue read, a stamp read and a decide step, and reset all scans
// every requester id between decode and the acknowledge and finish steps. The
// longest item is a gone holder with 63 entries queued: the compaction walk followed
// by a grant pass over 63 entries that are all on cooldown.
`default_nettype none
module token_semaphore_fifo_cooldown_top
  import tsf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_item_t         cmd,
  output logic                  valid,
  output out_item_t             result,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  state_t state, state_next;
  in_item_t cur, cur_next;
  logic [NUM_REQ-1:0] flags, flags_next, svalid, svalid_next;
  logic [CNT_W-1:0] count, count_next;
  logic [ID_W-1:0] head, head_next;
  logic [QLEN_W-1:0] qlen, qlen_next, idx, idx_next, wj, wj_next, k, k_next;
  logic [QLEN_W-1:0] examine, examine_next;
  logic rd_v, rd_v_next, found, found_next, gone_held, gone_held_next;
  logic [CNT_W-1:0] max_holders, lim;
  logic [TIME_W-1:0] cooldown;

  qmem_req_t qreq;
  smem_req_t sreq;
  logic [ID_W-1:0] q_rdata;
  logic [TIME_W-1:0] s_rdata;

  logic emit_en, finish;
  out_item_t emit_item, pend;
  logic pend_v;

  logic [ID_W-1:0] cid;
  assign cid = cur.requester_id;

  tsf_qmem u_qmem (.clk(clk), .req(qreq), .rdata(q_rdata));
  tsf_smem u_smem (.clk(clk), .req(sreq), .rdata(s_rdata));

  always_comb begin
    if (max_holders == '0) lim = CNT_W'(1);
    else if (max_holders > CNT_W'(MAX_HOLD)) lim = CNT_W'(MAX_HOLD);
    else lim = max_holders;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_holders <= CNT_W'(2);
      cooldown    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MAX_HOLDERS) max_holders <= cfg_data[CNT_W-1:0];
      else cooldown <= cfg_data[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      flags     <= '0;
      svalid    <= '0;
      count     <= '0;
      head      <= '0;
      qlen      <= '0;
      rd_v      <= 1'b0;
      found     <= 1'b0;
      gone_held <= 1'b0;
    end else begin
      state     <= state_next;
      flags     <= flags_next;
      svalid    <= svalid_next;
      count     <= count_next;
      head      <= head_next;
      qlen      <= qlen_next;
      rd_v      <= rd_v_next;
      found     <= found_next;
      gone_held <= gone_held_next;
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    idx     <= idx_next;
    wj      <= wj_next;
    k       <= k_next;
    examine <= examine_next;
  end

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    flags_next     = flags;
    svalid_next    = svalid;
    count_next     = count;
    head_next      = head;
    qlen_next      = qlen;
    idx_next       = idx;
    wj_next        = wj;
    k_next         = k;
    examine_next   = examine;
    rd_v_next      = rd_v;
    found_next     = found;
    gone_held_next = gone_held;
    qreq           = '0;
    sreq           = '0;
    emit_en        = 1'b0;
    emit_item      = '0;
    finish         = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cur_next   = cmd;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        idx_next  = '0;
        wj_next   = '0;
        rd_v_next = 1'b0;
        case (cur.mode)
          MODE_RESET_ALL: begin
            svalid_next = '0;
            qlen_next   = '0;
            state_next  = S_RST_SCAN;
          end
          MODE_REQUEST: begin
            found_next = 1'b0;
            sreq.re    = 1'b1;
            sreq.raddr = cid;
            state_next = S_REQ_SCAN;
          end
          MODE_RELEASE: begin
            if (flags[cid]) begin
              flags_next[cid] = 1'b0;
              count_next      = count - CNT_W'(1);
              emit_en   = 1'b1;
              emit_item = make_out(KIND_RELEASED, cid, ST_GRANTED, 1'b0, qlen,
                                   count - CNT_W'(1));
              k_next       = '0;
              examine_next = qlen;
              state_next   = S_GP_POP;
            end else begin
              emit_en    = 1'b1;
              emit_item  = make_out(KIND_ACK, cid, ST_GRANTED, 1'b0, qlen, count);
              state_next = S_FINISH;
            end
          end
          MODE_CANCEL: begin
            gone_held_next = 1'b0;
            state_next     = S_RM;
          end
          MODE_GONE: begin
            gone_held_next = flags[cid];
            if (flags[cid]) begin
              flags_next[cid] = 1'b0;
              count_next      = count - CNT_W'(1);
            end
            svalid_next[cid] = 1'b0;
            state_next       = S_RM;
          end
          default: begin
            emit_en    = 1'b1;
            emit_item  = make_out(KIND_ACK, cid, ST_GRANTED, flags[cid], qlen, count);
            state_next = S_FINISH;
          end
        endcase
      end
      S_REQ_SCAN: begin
        if (rd_v && (q_rdata == cid)) found_next = 1'b1;
        if (idx < qlen) begin
          qreq.re   = 1'b1;
          qreq.raddr = head + idx[ID_W-1:0];
          idx_next  = idx + QLEN_W'(1);
          rd_v_next = 1'b1;
        end else begin
          rd_v_next = 1'b0;
          if (!rd_v) state_next = S_REQ_DECIDE;
        end
      end
      S_REQ_DECIDE: begin
        emit_en    = 1'b1;
        state_next = S_FINISH;
        if (flags[cid]) begin
          emit_item = make_out(KIND_REPLY, cid, ST_HELD, 1'b1, qlen, count);
        end else if (found) begin
          emit_item = make_out(KIND_REPLY, cid, ST_QUEUED, 1'b0, qlen, count);
        end else if (cooling(cur.now_ticks, s_rdata, cooldown, svalid[cid])) begin
          emit_item = make_out(KIND_REPLY, cid, ST_COOL, 1'b0, qlen, count);
        end else if (count < lim) begin
          flags_next[cid]  = 1'b1;
          svalid_next[cid] = 1'b1;
          count_next       = count + CNT_W'(1);
          sreq.we    = 1'b1;
          sreq.waddr = cid;
          sreq.wdata = cur.now_ticks;
          emit_item  = make_out(KIND_REPLY, cid, ST_GRANTED, 1'b1, qlen,
                                count + CNT_W'(1));
        end else if (qlen < QLEN_W'(NUM_REQ)) begin
          qreq.we    = 1'b1;
          qreq.waddr = head + qlen[ID_W-1:0];
          qreq.wdata = cid;
          qlen_next  = qlen + QLEN_W'(1);
          emit_item  = make_out(KIND_REPLY, cid, ST_ENQUEUE, 1'b0,
                                qlen + QLEN_W'(1), count);
        end else begin
          emit_item = make_out(KIND_REPLY, cid, ST_COOL, 1'b0, qlen, count);
        end
      end
      S_RM: begin
        // compact in place: kept entries are written behind the read point
        if (rd_v && (q_rdata != cid)) begin
          qreq.we    = 1'b1;
          qreq.waddr = head + wj[ID_W-1:0];
          qreq.wdata = q_rdata;
          wj_next    = wj + QLEN_W'(1);
        end
        if (idx < qlen) begin
          qreq.re    = 1'b1;
          qreq.raddr = head + idx[ID_W-1:0];
          idx_next   = idx + QLEN_W'(1);
          rd_v_next  = 1'b1;
        end else begin
          rd_v_next = 1'b0;
          if (!rd_v) begin
            qlen_next = wj;
            emit_en   = 1'b1;
            emit_item = make_out(KIND_ACK, cid, ST_GRANTED, flags[cid], wj, count);
            if (gone_held) begin
              k_next       = '0;
              examine_next = wj;
              state_next   = S_GP_POP;
            end else begin
              state_next = S_FINISH;
            end
          end
        end
      end
      S_GP_POP: begin
        if ((k < examine) && (count < lim) && (qlen != '0)) begin
          qreq.re    = 1'b1;
          qreq.raddr = head;
          head_next  = head + ID_W'(1);
          qlen_next  = qlen - QLEN_W'(1);
          k_next     = k + QLEN_W'(1);
          state_next = S_GP_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_GP_RD: begin
        sreq.re    = 1'b1;
        sreq.raddr = q_rdata;
        state_next = S_GP_CHK;
      end
      S_GP_CHK: begin
        state_next = S_GP_POP;
        if (cooling(cur.now_ticks, s_rdata, cooldown, svalid[q_rdata])) begin
          // rotate to the back
          qreq.we    = 1'b1;
          qreq.waddr = head + qlen[ID_W-1:0];
          qreq.wdata = q_rdata;
          qlen_next  = qlen + QLEN_W'(1);
        end else begin
          flags_next[q_rdata]  = 1'b1;
          svalid_next[q_rdata] = 1'b1;
          count_next           = count + CNT_W'(1);
          sreq.we    = 1'b1;
          sreq.waddr = q_rdata;
          sreq.wdata = cur.now_ticks;
          emit_en    = 1'b1;
          emit_item  = make_out(KIND_GRANT, q_rdata, ST_GRANTED, 1'b1, qlen,
                                count + CNT_W'(1));
        end
      end
      S_RST_SCAN: begin
        if (flags[idx[ID_W-1:0]]) begin
          flags_next[idx[ID_W-1:0]] = 1'b0;
          count_next = count - CNT_W'(1);
          emit_en    = 1'b1;
          emit_item  = make_out(KIND_RELEASED, idx[ID_W-1:0], ST_GRANTED, 1'b0, '0,
                                count - CNT_W'(1));
        end
        if (idx == QLEN_W'(NUM_REQ - 1)) state_next = S_RST_ACK;
        else idx_next = idx + QLEN_W'(1);
      end
      S_RST_ACK: begin
        count_next = '0;
        emit_en    = 1'b1;
        emit_item  = make_out(KIND_ACK, '0, ST_GRANTED, 1'b0, '0, '0);
        state_next = S_FINISH;
      end
      S_FINISH: begin
        finish     = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // hold one result back so the final one can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      valid  <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (finish) begin
        valid       <= 1'b1;
        result      <= pend;
        result.last <= 1'b1;
        pend_v      <= 1'b0;
      end else if (emit_en) begin
        if (pend_v) begin
          valid  <= 1'b1;
          result <= pend;
        end
        pend   <= emit_item;
        pend_v <= 1'b1;
      end
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(count) == 32'($countones(flags)))
    else $error("holder count disagrees with holder flags");

  a_qlen_bound: assert property (@(posedge clk) disable iff (rst)
    qlen <= QLEN_W'(NUM_REQ))
    else $error("queue length beyond capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted without going busy");

  a_last_quiet: assert property (@(posedge clk) disable iff (rst)
    (valid && result.last) |-> !busy ##1 !valid)
    else $error("activity after final result");

endmodule
`default_nettype wire

FILE: src/tsf_qmem.sv
// Wait queue storage: one write port, one registered read port.
`default_nettype none
module tsf_qmem
  import tsf_pkg::*;
(
  input  wire logic             clk,
  input  wire qmem_req_t        req,
  output logic     [ID_W-1:0]   rdata
);

  logic [ID_W-1:0] mem [NUM_REQ];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    if (req.re) rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

FILE: src/tsf_smem.sv
// Grant stamp storage per requester: one write port, one registered read port.
`default_nettype none
module tsf_smem
  import tsf_pkg::*;
(
  input  wire logic             clk,
  input  wire smem_req_t        req,
  output logic     [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0] mem [NUM_REQ];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    if (req.re) rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire
